### src/scheduled_pwm_fade_controller_defines.svh
// Assertion macros used by the back end of the scheduled PWM fade controller RTL.
`ifndef SCHEDULED_PWM_FADE_CONTROLLER_DEFINES_SVH
`define SCHEDULED_PWM_FADE_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define SPFC_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/spfc_pkg.sv
// Types, constants and helpers of the scheduled PWM fade controller.
package spfc_pkg;

   localparam int MAX_EVENTS    = 4;
   localparam int EV_IDX_BITS   = 2;
   localparam int LEVEL_BITS    = 12;
   localparam int WORD_BITS     = 46;
   localparam int SEC_BITS      = 17;
   localparam int SPAN_BITS     = 27;
   localparam int DIFF_BITS     = 13;
   localparam int DIV_NUM_BITS  = 39;
   localparam int DIV_DEN_BITS  = 27;
   localparam int DIV_CNT_BITS  = 6;
   localparam int QUEUE_DEPTH   = 2;
   localparam int DAY_SECONDS   = 86400;
   localparam int MS_PER_SECOND = 1000;

   localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = '1;

   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_ON      = 3'd1;
   localparam logic [2:0] CMD_OFF     = 3'd2;
   localparam logic [2:0] CMD_TOGGLE  = 3'd3;
   localparam logic [2:0] CMD_SET     = 3'd4;
   localparam logic [2:0] CMD_SUSPEND = 3'd5;

   localparam logic [2:0] CSR_EVENT_COUNT = 3'd0;
   localparam logic [2:0] CSR_DAY_MASK    = 3'd1;
   localparam logic [2:0] CSR_FOLLOW      = 3'd2;
   localparam logic [2:0] CSR_EVENT_0     = 3'd3;
   localparam logic [2:0] CSR_EVENT_1     = 3'd4;
   localparam logic [2:0] CSR_EVENT_2     = 3'd5;
   localparam logic [2:0] CSR_EVENT_3     = 3'd6;

   typedef struct packed {
      logic [2:0]            command;
      logic [2:0]            weekday;
      logic [SEC_BITS-1:0]   time_of_day;
      logic [31:0]           now_ms;
      logic                  dependent_on;
      logic [LEVEL_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  device_on;
      logic                  last;
   } rsp_type;

   typedef enum logic [2:0] {
      CLS_TICK, CLS_ON, CLS_OFF, CLS_TOGGLE, CLS_SET, CLS_SUSPEND, CLS_DROP
   } cls_type;

   typedef struct packed {
      cls_type cls;
      req_type item;
   } q_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_FOLLOW, ST_EV_START, ST_EV_DIV_A, ST_EV_WIN,
      ST_EV_MUL, ST_EV_DIV_B, ST_EV_STEP, ST_EV_END, ST_FINISH
   } state_type;

   function automatic logic [SEC_BITS-1:0] ev_start(input logic [WORD_BITS-1:0] w);
      ev_start = w[16:0];
   endfunction

   function automatic logic [SEC_BITS-1:0] ev_duration(input logic [WORD_BITS-1:0] w);
      ev_duration = w[33:17];
   endfunction

   function automatic logic [LEVEL_BITS-1:0] ev_target(input logic [WORD_BITS-1:0] w);
      ev_target = w[45:34];
   endfunction

endpackage

### src/spfc_front.sv
// Front end: accepts items, classifies the command and queues them.
module spfc_front import spfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        q_valid,
   output q_entry_type q_entry,
   input  logic        q_pop
);

   q_entry_type mem_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cls_type     cls;
   logic        push, pop;

   always_comb begin
      unique case (req_payload.command)
         CMD_TICK:    cls = CLS_TICK;
         CMD_ON:      cls = CLS_ON;
         CMD_OFF:     cls = CLS_OFF;
         CMD_TOGGLE:  cls = CLS_TOGGLE;
         CMD_SET:     cls = CLS_SET;
         CMD_SUSPEND: cls = CLS_SUSPEND;
         default:     cls = CLS_DROP;
      endcase
   end

   assign req_stall = (count_ff == 2'(QUEUE_DEPTH));
   // Drop unknown commands here: they cause nothing downstream.
   assign push      = req_valid && !req_stall && (cls != CLS_DROP);
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = mem_ff[rd_ptr_ff];
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{cls: cls, item: req_payload};
      end
   end

endmodule

### src/spfc_divider.sv
// Restoring divider, one quotient bit per cycle.
module spfc_divider import spfc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIV_NUM_BITS-1:0] num,
   input  logic [DIV_DEN_BITS-1:0] den,
   output div_stat_type            stat,
   output logic [DIV_NUM_BITS-1:0] quo,
   output logic [DIV_DEN_BITS-1:0] rem
);

   logic [DIV_NUM_BITS-1:0] quo_ff, quo_in;
   logic [DIV_DEN_BITS-1:0] rem_ff, rem_in;
   logic [DIV_DEN_BITS-1:0] den_ff, den_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_DEN_BITS:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_NUM_BITS-1]};
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = DIV_CNT_BITS'(DIV_NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_BITS'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_BITS-1:0];
            quo_in = {quo_ff[DIV_NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat = '{busy: busy_ff, done: done_ff};
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

### src/spfc_back.sv
// Back end: configuration, fade state, event sequencer and result output.
`include "scheduled_pwm_fade_controller_defines.svh"
module spfc_back import spfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  q_entry_type          q_entry,
   output logic                 q_pop,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [WORD_BITS-1:0] csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload
);

   // configuration
   logic [2:0]           event_count_ff;
   logic [6:0]           day_mask_ff;
   logic                 follow_ff;
   logic [WORD_BITS-1:0] ev_word_ff [MAX_EVENTS];

   state_type               state_ff, state_in;
   q_entry_type             cur_ff, cur_in;
   logic [EV_IDX_BITS-1:0]  ev_idx_ff, ev_idx_in;
   logic                    fade_active_ff, fade_active_in;
   logic [LEVEL_BITS-1:0]   settled_ff, settled_in;
   logic [LEVEL_BITS-1:0]   current_ff, current_in;
   logic [31:0]             origin_ff, origin_in;
   logic [31:0]             next_step_ff, next_step_in;
   logic [SPAN_BITS-1:0]    span_ff, span_in;
   logic signed [DIFF_BITS-1:0] diff_ff, diff_in;
   logic [SPAN_BITS-1:0]    interval_ff, interval_in;
   logic                    on_flag_ff, on_flag_in;
   logic                    suspended_ff, suspended_in;
   logic [DIV_NUM_BITS-1:0] prod_ff, prod_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [LEVEL_BITS-1:0]   pend_level_ff, pend_level_in;
   logic                    pend_on_ff, pend_on_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    div_start;
   logic [DIV_NUM_BITS-1:0] div_num;
   logic [DIV_DEN_BITS-1:0] div_den;
   div_stat_type            div_stat;
   logic [DIV_NUM_BITS-1:0] div_quo;
   logic [DIV_DEN_BITS-1:0] div_rem;

   logic [WORD_BITS-1:0]    ev_word;
   logic [SEC_BITS:0]       start18, t18, end_sum, ev_end, ev_len;
   logic [LEVEL_BITS-1:0]   ev_tgt;
   logic [SPAN_BITS-1:0]    span_calc;
   logic signed [DIFF_BITS-1:0] diff_calc;
   logic [LEVEL_BITS-1:0]   mag_calc, mag_ff;
   logic [31:0]             elapsed, since_step;
   logic [2:0]              ev_cnt;
   logic                    ev_last, is_day, win, due;
   logic                    out_free, can_emit, emit_req;
   logic [LEVEL_BITS-1:0]   emit_level;
   logic [LEVEL_BITS-1:0]   q_lvl;
   logic [LEVEL_BITS:0]     up_sum;
   logic [LEVEL_BITS+1:0]   dn_sum;

   spfc_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         event_count_ff <= '0;
         day_mask_ff    <= '0;
         follow_ff      <= 1'b0;
         for (int i = 0; i < MAX_EVENTS; i++) begin
            ev_word_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_EVENT_COUNT: event_count_ff <= csr_data[2:0];
            CSR_DAY_MASK:    day_mask_ff    <= csr_data[6:0];
            CSR_FOLLOW:      follow_ff      <= csr_data[0];
            CSR_EVENT_0:     ev_word_ff[0]  <= csr_data;
            CSR_EVENT_1:     ev_word_ff[1]  <= csr_data;
            CSR_EVENT_2:     ev_word_ff[2]  <= csr_data;
            CSR_EVENT_3:     ev_word_ff[3]  <= csr_data;
            default: ;
         endcase
      end
   end

   // Event decode for the event under work.
   always_comb begin
      ev_word   = ev_word_ff[ev_idx_ff];
      start18   = {1'b0, ev_start(ev_word)};
      ev_tgt    = ev_target(ev_word);
      end_sum   = start18 + {1'b0, ev_duration(ev_word)};
      ev_end    = (end_sum > (SEC_BITS+1)'(DAY_SECONDS)) ?
                  end_sum - (SEC_BITS+1)'(DAY_SECONDS) : end_sum;
      ev_len    = ev_end - start18;
      span_calc = (ev_end > start18) ?
                  SPAN_BITS'(28'(ev_len) * 28'(MS_PER_SECOND)) : '0;
      diff_calc = $signed({1'b0, ev_tgt}) - $signed({1'b0, settled_ff});
      mag_calc  = diff_calc[DIFF_BITS-1] ? LEVEL_BITS'(-diff_calc) : diff_calc[LEVEL_BITS-1:0];
      mag_ff    = diff_ff[DIFF_BITS-1] ? LEVEL_BITS'(-diff_ff) : diff_ff[LEVEL_BITS-1:0];
      t18       = {1'b0, cur_ff.item.time_of_day};
      elapsed   = cur_ff.item.now_ms - origin_ff;
      since_step = cur_ff.item.now_ms - next_step_ff;
      ev_cnt    = (event_count_ff > 3'(MAX_EVENTS)) ? 3'(MAX_EVENTS) : event_count_ff;
      ev_last   = ((3'(ev_idx_ff) + 3'd1) == ev_cnt);
      is_day    = (cur_ff.item.weekday < 3'd7) && day_mask_ff[cur_ff.item.weekday];
      win       = (t18 >= start18) && (t18 < ev_end) && fade_active_ff;
      due       = (since_step >= 32'(interval_ff));
      // fade level from the finished quotient (never above the magnitude)
      q_lvl     = div_quo[LEVEL_BITS-1:0];
      up_sum    = {1'b0, settled_ff} + {1'b0, q_lvl};
      dn_sum    = {2'b0, settled_ff} - {2'b0, q_lvl} - (LEVEL_BITS+2)'(div_rem != '0);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_emit = !pend_valid_ff || out_free;

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      ev_idx_in      = ev_idx_ff;
      fade_active_in = fade_active_ff;
      settled_in     = settled_ff;
      current_in     = current_ff;
      origin_in      = origin_ff;
      next_step_in   = next_step_ff;
      span_in        = span_ff;
      diff_in        = diff_ff;
      interval_in    = interval_ff;
      on_flag_in     = on_flag_ff;
      suspended_in   = suspended_ff;
      prod_in        = prod_ff;
      pend_valid_in  = pend_valid_ff;
      pend_level_in  = pend_level_ff;
      pend_on_in     = pend_on_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      q_pop          = 1'b0;
      div_start      = 1'b0;
      div_num        = {{(DIV_NUM_BITS-SPAN_BITS){1'b0}}, span_in};
      div_den        = {{(DIV_DEN_BITS-LEVEL_BITS){1'b0}}, mag_calc};
      emit_req       = 1'b0;
      emit_level     = current_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_entry;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (can_emit) begin
               state_in = ST_FINISH;
               unique case (cur_ff.cls)
                  CLS_ON: begin
                     on_flag_in = 1'b1;
                     emit_req   = 1'b1;
                     emit_level = LEVEL_FULL;
                  end
                  CLS_OFF: begin
                     on_flag_in = 1'b0;
                     emit_req   = 1'b1;
                     emit_level = '0;
                  end
                  CLS_TOGGLE: begin
                     on_flag_in = !on_flag_ff;
                     emit_req   = 1'b1;
                     emit_level = on_flag_ff ? '0 : LEVEL_FULL;
                  end
                  CLS_SET: begin
                     emit_req   = 1'b1;
                     emit_level = cur_ff.item.value;
                  end
                  CLS_SUSPEND: begin
                     suspended_in = (cur_ff.item.value != '0);
                     emit_req     = 1'b1;
                     emit_level   = current_ff;
                  end
                  CLS_TICK: begin
                     if (!suspended_ff) begin
                        state_in = ST_FOLLOW;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FOLLOW: begin
            if (can_emit) begin
               if ((ev_cnt == 3'd0) && follow_ff) begin
                  on_flag_in = cur_ff.item.dependent_on;
                  emit_req   = 1'b1;
                  emit_level = cur_ff.item.dependent_on ? LEVEL_FULL : '0;
               end
               ev_idx_in = '0;
               state_in  = (is_day && !follow_ff && (ev_cnt != 3'd0)) ? ST_EV_START : ST_FINISH;
            end
         end
         ST_EV_START: begin
            if (can_emit) begin
               on_flag_in = (current_ff != '0);
               state_in   = ST_EV_WIN;
               if ((t18 == start18) && !fade_active_ff) begin
                  fade_active_in = 1'b1;
                  origin_in      = cur_ff.item.now_ms;
                  next_step_in   = cur_ff.item.now_ms;
                  if (start18 == ev_end) begin
                     // zero-length window: write the target and end the fade
                     emit_req       = 1'b1;
                     emit_level     = ev_tgt;
                     fade_active_in = 1'b0;
                  end
                  span_in = span_calc;
                  diff_in = diff_calc;
                  if (mag_calc == '0) begin
                     interval_in = span_calc;
                  end else begin
                     // step interval: new span over the level magnitude
                     div_start = 1'b1;
                     div_num   = {{(DIV_NUM_BITS-SPAN_BITS){1'b0}}, span_calc};
                     state_in  = ST_EV_DIV_A;
                  end
               end
            end
         end
         ST_EV_DIV_A: begin
            if (div_stat.done) begin
               interval_in = div_quo[SPAN_BITS-1:0];
               state_in    = ST_EV_WIN;
            end
         end
         ST_EV_WIN: begin
            if (win && due) begin
               if ((span_ff != '0) && (elapsed <= 32'(span_ff))) begin
                  prod_in  = DIV_NUM_BITS'(mag_ff) * DIV_NUM_BITS'(elapsed[SPAN_BITS-1:0]);
                  state_in = ST_EV_MUL;
               end else begin
                  state_in = ST_EV_STEP;
               end
            end else if (!win && (t18 == ev_end) && fade_active_ff) begin
               state_in = ST_EV_END;
            end else begin
               ev_idx_in = ev_idx_ff + 1'b1;
               state_in  = ev_last ? ST_FINISH : ST_EV_START;
            end
         end
         ST_EV_MUL: begin
            div_start = 1'b1;
            div_num   = prod_ff;
            div_den   = span_ff;
            state_in  = ST_EV_DIV_B;
         end
         ST_EV_DIV_B: begin
            if (div_stat.done) begin
               if (diff_ff[DIFF_BITS-1]) begin
                  current_in = dn_sum[LEVEL_BITS+1] ? '0 : dn_sum[LEVEL_BITS-1:0];
               end else begin
                  current_in = up_sum[LEVEL_BITS] ? LEVEL_FULL : up_sum[LEVEL_BITS-1:0];
               end
               state_in = ST_EV_STEP;
            end
         end
         ST_EV_STEP: begin
            if (can_emit) begin
               emit_req     = 1'b1;
               emit_level   = current_ff;
               next_step_in = next_step_ff + 32'(interval_ff);
               ev_idx_in    = ev_idx_ff + 1'b1;
               state_in     = ev_last ? ST_FINISH : ST_EV_START;
            end
         end
         ST_EV_END: begin
            if (can_emit) begin
               fade_active_in = 1'b0;
               settled_in     = ev_tgt;
               emit_req       = 1'b1;
               emit_level     = ev_tgt;
               ev_idx_in      = ev_idx_ff + 1'b1;
               state_in       = ev_last ? ST_FINISH : ST_EV_START;
            end
         end
         ST_FINISH: begin
            // release the held result as the final one of this transaction
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '{level: pend_level_ff, device_on: pend_on_ff, last: 1'b1};
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Hold each new result back one step so that the last one can be marked.
      if (emit_req) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{level: pend_level_ff, device_on: pend_on_ff, last: 1'b0};
         end
         pend_valid_in = 1'b1;
         pend_level_in = emit_level;
         pend_on_in    = on_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ev_idx_ff      <= '0;
         fade_active_ff <= 1'b0;
         settled_ff     <= '0;
         current_ff     <= '0;
         origin_ff      <= '0;
         next_step_ff   <= '0;
         span_ff        <= '0;
         diff_ff        <= '0;
         interval_ff    <= '0;
         on_flag_ff     <= 1'b0;
         suspended_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ev_idx_ff      <= ev_idx_in;
         fade_active_ff <= fade_active_in;
         settled_ff     <= settled_in;
         current_ff     <= current_in;
         origin_ff      <= origin_in;
         next_step_ff   <= next_step_in;
         span_ff        <= span_in;
         diff_ff        <= diff_in;
         interval_ff    <= interval_in;
         on_flag_ff     <= on_flag_in;
         suspended_ff   <= suspended_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prod_ff       <= prod_in;
      pend_level_ff <= pend_level_in;
      pend_on_ff    <= pend_on_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SPFC_ASSERT_HOLDS(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_valid_ff, "result held over into idle")
   `SPFC_ASSERT_HOLDS(a_div_start_free, clock, reset, div_start, !div_stat.busy, "divider restarted while busy")
   `SPFC_ASSERT_NEXT(a_div_runs, clock, reset, div_start, div_stat.busy, "divider did not start")
   `SPFC_ASSERT_HOLDS(a_event_index, clock, reset, state_ff == ST_EV_START, 3'(ev_idx_ff) < ev_cnt, "event index beyond count")

endmodule

### src/scheduled_pwm_fade_controller.sv
// Top level of the scheduled PWM fade controller.
//
// Each input transaction is a tick (weekday, second of day, millisecond count)
// or a command (on, off, toggle, set level, set suspend); each output
// transaction is one write to the PWM channel, with last set on the final
// write caused by an input transaction. The front end classifies commands,
// drops unknown ones and queues up to two transactions; the back end works
// them one at a time, so the queue can still take input while a result waits
// on rsp_stall. The work of a tick on each enabled event is set mostly by the
// single shared restoring divider, which is used at most once when a fade
// starts (step interval) and at most once per fade step (level); a tick
// also takes longer while rsp_stall holds a result. Configuration is written
// through csr_write/csr_index/csr_data; the user must write it only while
// the block is idle, which the block itself does not enforce.
module scheduled_pwm_fade_controller import spfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [WORD_BITS-1:0] csr_data
);

   logic        q_valid;
   q_entry_type q_entry;
   logic        q_pop;

   // Accept, classify and queue transactions.
   spfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop)
   );

   // Run schedule and fades, drive the channel writes.
   spfc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### verif/fade_checker.sv
// Checker for the scheduled PWM fade controller: predicts channel writes and compares them.
`timescale 1ns / 1ps
module fade_checker import spfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_payload,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [WORD_BITS-1:0] csr_data,
   output int                   fail_count,
   output int                   pending_writes,
   output int                   writes_seen
);
   // shadow configuration
   logic [2:0]           ev_count;
   logic [6:0]           days;
   logic                 follow;
   logic [WORD_BITS-1:0] ev_word [MAX_EVENTS];
   // shadow fade state
   logic        fading, dev_on, susp;
   logic [11:0] settled, current;
   logic [31:0] origin_ms, step_ms;
   logic [26:0] span_ms, interval_ms;
   int          diff;

   rsp_type expected_writes[$];

   function automatic logic [11:0] ramp_level(logic [31:0] elapsed);
      longint unsigned mag, num, q;
      longint r;
      mag = diff < 0 ? -diff : diff;
      num = mag * elapsed;
      q = num / span_ms;
      if (diff < 0) r = longint'(settled) - longint'(q) - ((num % span_ms) != 0 ? 1 : 0);
      else r = longint'(settled) + longint'(q);
      if (r < 0) r = 0;
      if (r > 4095) r = 4095;
      return r[11:0];
   endfunction

   task automatic push_write(logic [11:0] lvl);
      rsp_type w;
      w.level = lvl;
      w.device_on = dev_on;
      w.last = 1'b0;
      expected_writes.push_back(w);
   endtask

   task automatic predict_tick(req_type r);
      int cnt;
      logic is_day;
      logic [16:0] st, du;
      logic [11:0] tg;
      logic [31:0] en, mag;
      if (susp) return;
      cnt = ev_count > MAX_EVENTS ? MAX_EVENTS : ev_count;
      if (cnt == 0 && follow) begin
         dev_on = r.dependent_on;
         push_write(dev_on ? LEVEL_FULL : 12'd0);
      end
      is_day = r.weekday < 7 && days[r.weekday];
      for (int i = 0; i < cnt; i++) begin
         if (!is_day || follow) continue;
         dev_on = current > 0;
         st = ev_start(ev_word[i]);
         du = ev_duration(ev_word[i]);
         tg = ev_target(ev_word[i]);
         en = 32'(st) + 32'(du);
         if (en > DAY_SECONDS) en -= DAY_SECONDS;
         if (r.time_of_day == st && !fading) begin
            fading = 1;
            origin_ms = r.now_ms;
            step_ms = r.now_ms;
            if (32'(st) == en) begin
               push_write(tg);
               fading = 0;
            end
            span_ms = en > st ? 27'((en - st) * 1000) : 27'd0;
            diff = int'(tg) - int'(settled);
            mag = diff < 0 ? -diff : diff;
            interval_ms = mag == 0 ? span_ms : 27'(span_ms / mag);
         end
         if (r.time_of_day >= st && 32'(r.time_of_day) < en && fading) begin
            if (r.now_ms - step_ms >= 32'(interval_ms)) begin
               if (span_ms > 0 && r.now_ms - origin_ms <= 32'(span_ms))
                  current = ramp_level(r.now_ms - origin_ms);
               push_write(current);
               step_ms += 32'(interval_ms);
            end
         end else if (32'(r.time_of_day) == en && fading) begin
            fading = 0;
            settled = tg;
            push_write(settled);
         end
      end
   endtask

   task automatic predict_item(req_type r);
      int before_n;
      before_n = expected_writes.size();
      case (r.command)
         CMD_TICK:    predict_tick(r);
         CMD_ON:      begin dev_on = 1; push_write(LEVEL_FULL); end
         CMD_OFF:     begin dev_on = 0; push_write(12'd0); end
         CMD_TOGGLE:  begin dev_on = !dev_on; push_write(dev_on ? LEVEL_FULL : 12'd0); end
         CMD_SET:     push_write(r.value);
         CMD_SUSPEND: begin susp = r.value != 0; push_write(current); end
         default: ;
      endcase
      if (expected_writes.size() > before_n)
         expected_writes[$].last = 1'b1;
   endtask

   assign pending_writes = expected_writes.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ev_count <= 0; days <= 0; follow <= 0;
         for (int i = 0; i < MAX_EVENTS; i++) ev_word[i] <= '0;
         fading = 0; dev_on = 0; susp = 0; settled = 0; current = 0;
         origin_ms = 0; step_ms = 0; span_ms = 0; interval_ms = 0; diff = 0;
         expected_writes.delete();
         fail_count <= 0;
         writes_seen <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_EVENT_COUNT: ev_count <= csr_data[2:0];
               CSR_DAY_MASK:    days <= csr_data[6:0];
               CSR_FOLLOW:      follow <= csr_data[0];
               CSR_EVENT_0:     ev_word[0] <= csr_data;
               CSR_EVENT_1:     ev_word[1] <= csr_data;
               CSR_EVENT_2:     ev_word[2] <= csr_data;
               CSR_EVENT_3:     ev_word[3] <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_item(req_payload);
         if (rsp_valid && !rsp_stall) begin
            writes_seen <= writes_seen + 1;
            if (expected_writes.size() == 0) begin
               $error("unexpected channel write level=%0d", rsp_payload.level);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_writes.pop_front();
               if (rsp_payload.level !== want.level) begin
                  $error("level expected %0d actual %0d", want.level, rsp_payload.level);
                  fail_count <= fail_count + 1;
               end
               if (rsp_payload.device_on !== want.device_on) begin
                  $error("device_on expected %0d actual %0d",
                         want.device_on, rsp_payload.device_on);
                  fail_count <= fail_count + 1;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_payload.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### verif/testbench.sv
// Stimulus and verdict for the scheduled PWM fade controller.
`timescale 1ns / 1ps
module testbench import spfc_pkg::*;;
   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   rsp_type              rsp_payload;
   logic                 csr_write = 0;
   logic [2:0]           csr_index = '0;
   logic [WORD_BITS-1:0] csr_data = '0;
   int fail_count, pending_writes, writes_seen;
   int items_sent = 0;
   int idle_cycles = 0;
   logic hold_off = 0;      // long receiver stall requested by the stimulus
   logic stimulus_done = 0;
   localparam int WATCHDOG = 20000;
   localparam int DRAIN = 600;   // settle time for the block's own work after the last write

   // running clock model for ticks
   logic [31:0] sim_ms = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   scheduled_pwm_fade_controller dut (.*);

   fade_checker checker_inst (.*);

   // Receiver: stall in its own pattern; hold off for a long stretch on request.
   always @(posedge clock) begin
      int mode;
      if (reset) rsp_stall <= 0;
      else if (hold_off) rsp_stall <= 1;
      else begin
         mode = (items_sent / 40) % 3;
         if (mode == 0) rsp_stall <= 0;
         else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   // Watchdog on cycles with no accepted transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send(req_type r);
      req_valid <= 1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic gap();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [WORD_BITS-1:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
   endtask

   // Stop offering, wait for all writes, then let the block's own work finish.
   task automatic quiesce();
      req_valid <= 0;
      @(posedge clock);
      while (pending_writes != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] ev_pack(logic [16:0] st, logic [16:0] du,
                                                  logic [11:0] tg);
      return {tg, du, st};
   endfunction

   function automatic req_type make_tick(logic [2:0] wd, logic [16:0] t, logic [31:0] ms,
                                         logic dep);
      req_type r;
      r = '0;
      r.command = CMD_TICK;
      r.weekday = wd;
      r.time_of_day = t;
      r.now_ms = ms;
      r.dependent_on = dep;
      r.value = 12'($urandom);
      return r;
   endfunction

   function automatic req_type make_cmd(logic [2:0] c, logic [11:0] v);
      req_type r;
      r = '0;
      r.command = c;
      r.value = v;
      r.weekday = 3'($urandom);
      r.time_of_day = 17'($urandom);
      r.now_ms = $urandom;
      r.dependent_on = 1'($urandom);
      return r;
   endfunction

   // Program mostly short random events for a phase; starts cluster so fades overlap ticks.
   task automatic program_events(int cnt, logic [6:0] mask, logic fol);
      logic [16:0] st, du;
      write_csr(CSR_EVENT_COUNT, WORD_BITS'(cnt));
      write_csr(CSR_DAY_MASK, WORD_BITS'(mask));
      write_csr(CSR_FOLLOW, WORD_BITS'(fol));
      for (int i = 0; i < MAX_EVENTS; i++) begin
         st = 17'($urandom_range(100, 110) + 20 * i);
         case ($urandom_range(0, 5))
            0: du = 0;
            1: du = 17'($urandom_range(86300, 131071));
            default: du = 17'($urandom_range(1, 6));
         endcase
         write_csr(3'(CSR_EVENT_0 + i), ev_pack(st, du, 12'($urandom)));
      end
   endtask

   // One phase: tick sweeps across the event windows, with commands mixed in.
   task automatic run_phase(int n);
      int burst;
      logic [16:0] t;
      req_type r;
      t = 17'($urandom_range(95, 100));
      burst = $urandom_range(1, 12);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 19))
            0: r = make_cmd(3'($urandom_range(CMD_ON, CMD_SET)), 12'($urandom));
            1: r = make_cmd(CMD_SUSPEND, ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'd0);
            2: r = make_cmd(3'($urandom_range(6, 7)), 12'($urandom));
            3: r = make_tick(3'($urandom), 17'($urandom), $urandom, 1'($urandom));
            default: begin
               if ($urandom_range(0, 2) != 0) t = t + 17'd1;
               if (t > 190) t = 17'($urandom_range(95, 100));
               sim_ms = sim_ms + $urandom_range(0, 1500);
               r = make_tick(($urandom_range(0, 7) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
                             t, sim_ms, 1'($urandom));
            end
         endcase
         send(r);
         if (--burst == 0) begin
            gap();
            burst = $urandom_range(1, 12);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: follow mode, commands, extreme fields, unknown codes.
      write_csr(CSR_FOLLOW, WORD_BITS'(1));
      send(make_tick(3'd0, 17'd0, 32'd0, 1'b1));
      send(make_tick(3'd7, 17'd86399, 32'hFFFF_FFFF, 1'b0));
      send(make_cmd(CMD_ON, 12'd0));
      send(make_cmd(CMD_OFF, 12'hFFF));
      send(make_cmd(CMD_TOGGLE, 12'd0));
      send(make_cmd(CMD_TOGGLE, 12'd0));
      send(make_cmd(CMD_SET, 12'hFFF));
      send(make_cmd(CMD_SET, 12'd0));
      send(make_cmd(3'd6, 12'd5));
      send(make_cmd(3'd7, 12'hFFF));
      send(make_cmd(CMD_SUSPEND, 12'd1));
      send(make_tick(3'd1, 17'd5, 32'd10, 1'b1));
      send(make_cmd(CMD_SUSPEND, 12'd0));
      quiesce();

      // Directed: one event, wrap past midnight, zero duration, then overflowed count.
      write_csr(CSR_FOLLOW, WORD_BITS'(0));
      write_csr(CSR_DAY_MASK, WORD_BITS'(7'h7F));
      write_csr(CSR_EVENT_COUNT, WORD_BITS'(1));
      write_csr(CSR_EVENT_0, ev_pack(17'd10, 17'd2, 12'hFFF));
      send(make_tick(3'd6, 17'd10, 32'd1000, 1'b0));
      send(make_tick(3'd6, 17'd11, 32'd1800, 1'b0));
      send(make_tick(3'd6, 17'd12, 32'd3000, 1'b0));
      quiesce();
      write_csr(CSR_EVENT_0, ev_pack(17'd86399, 17'h1FFFF, 12'd0));
      write_csr(CSR_EVENT_1, ev_pack(17'd50, 17'd0, 12'd77));
      write_csr(CSR_EVENT_2, ev_pack(17'h1FFFF, 17'h1FFFF, 12'hFFF));
      write_csr(CSR_EVENT_3, ev_pack(17'd0, 17'd1, 12'd1));
      write_csr(CSR_EVENT_COUNT, WORD_BITS'(7));
      send(make_tick(3'd0, 17'd86399, 32'hFFFF_FF00, 1'b0));
      send(make_tick(3'd0, 17'd50, 32'h0000_0100, 1'b0));
      send(make_tick(3'd0, 17'h1FFFF, 32'h0000_0200, 1'b1));
      send(make_tick(3'd0, 17'd0, 32'h0000_0300, 1'b0));
      quiesce();

      // Long receiver hold-off while ticks keep being offered.
      write_csr(CSR_EVENT_COUNT, WORD_BITS'(0));
      write_csr(CSR_FOLLOW, WORD_BITS'(1));
      hold_off <= 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off <= 0;
         end
         for (int k = 0; k < 8; k++) send(make_tick(3'($urandom), 17'd1, 32'd1, 1'($urandom)));
      join
      quiesce();

      // Random phases through several configurations, extremes included.
      for (int p = 0; p < 10; p++) begin
         case (p % 5)
            0: program_events(4, 7'h7F, 0);
            1: program_events($urandom_range(1, 7), 7'($urandom), 0);
            2: program_events(0, 7'($urandom), 1);
            3: program_events($urandom_range(1, 4), 7'h00, 0);
            default: program_events($urandom_range(0, 4), 7'($urandom), 1'($urandom));
         endcase
         run_phase(30);
         quiesce();
      end

      req_valid <= 0;
      stimulus_done <= 1;
   end

   // Verdict once stimulus is done and the last write has drained.
   initial begin
      wait (stimulus_done);
      while (pending_writes != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("covered %0d input transactions and %0d channel writes", items_sent, writes_seen);
      $display("across follow mode, fades, direct commands and suspend");
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
